### hdl/rcf_pkg.sv
`timescale 1ns / 1ps

package rcf_pkg;

  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 4096;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = 12;
  localparam int WidthW    = 12;
  localparam int HeightW   = 13;
  localparam int PixW      = 24;
  localparam int SumW      = 20;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KERNEL_TOP    = 3'd0,
    CFG_KERNEL_MIDDLE = 3'd1,
    CFG_KERNEL_BOTTOM = 3'd2,
    CFG_DIVISOR       = 3'd3,
    CFG_IMAGE_WIDTH   = 3'd4,
    CFG_IMAGE_HEIGHT  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      red_out;
    logic [7:0]      green_out;
    logic [7:0]      blue_out;
    logic [ColW-1:0] center_x;
    logic [RowW-1:0] center_y;
    logic            frame_last;
  } out_item_t;

  // line store entry: lower line in the high half, upper line in the low half
  typedef struct packed {
    logic [PixW-1:0] lower;
    logic [PixW-1:0] upper;
  } line_entry_t;

endpackage

### hdl/rcf_line_mem.sv
`timescale 1ns / 1ps

module rcf_line_mem (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [rcf_pkg::ColW-1:0] rd_addr,
  output rcf_pkg::line_entry_t    rd_data,
  input  logic                    wr_en,
  input  logic [rcf_pkg::ColW-1:0] wr_addr,
  input  rcf_pkg::line_entry_t    wr_data
);

  rcf_pkg::line_entry_t mem [rcf_pkg::MaxWidth];
  rcf_pkg::line_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/rcf_div.sv
`timescale 1ns / 1ps

module rcf_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [rcf_pkg::SumW-1:0] dividend,
  input  logic [7:0]                      divisor,
  output logic                            done,
  output logic [7:0]                      quotient
);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t     state_r;
  logic        done_r;
  logic [7:0]  q_r;
  logic [15:0] rem_r;
  logic [15:0] dsh_r;
  logic [2:0]  cnt_r;
  logic [7:0]  d_eff;
  logic        ge;

  // zero divisor acts as one
  assign d_eff = (divisor == 8'd0) ? 8'd1 : divisor;
  assign ge    = (rem_r >= dsh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            // negative sums clamp to zero, large quotients saturate
            if (dividend[rcf_pkg::SumW-1]) begin
              q_r    <= 8'd0;
              done_r <= 1'b1;
            end else if (dividend[rcf_pkg::SumW-2:0] >= {3'b000, d_eff, 8'h00}) begin
              q_r    <= 8'hFF;
              done_r <= 1'b1;
            end else begin
              rem_r   <= dividend[15:0];
              dsh_r   <= {1'b0, d_eff, 7'b0};
              q_r     <= 8'd0;
              cnt_r   <= 3'd7;
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (ge) begin
            rem_r <= rem_r - dsh_r;
          end
          q_r   <= {q_r[6:0], ge};
          dsh_r <= {1'b0, dsh_r[15:1]};
          cnt_r <= cnt_r - 3'd1;
          if (cnt_r == 3'd0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

  a_run_not_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_RUN) |-> !done_r || $past(state_r) == D_RUN)
    else $error("divider done out of sequence");

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == D_IDLE)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

endmodule

### hdl/rgb_conv3x3_filter_top.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall   | in_data  (rcf_pkg::in_item_t)
// out_    | output    | out_valid/out_stall | out_data (rcf_pkg::out_item_t)
// cfg_    | input     | cfg_wen             | cfg_idx, cfg_wdata
//
// One item at a time. A border pixel takes a line store read, then
// write-back. An interior pixel then takes a multiply-accumulate over the
// nine taps (three channels in parallel), the shared iterative divider
// (8 quotient bits, one channel after another) and the output state, which
// holds through any output stall. in_stall stays high until the result item
// has been taken (a border pixel: until write-back). Reset (rst_n low,
// synchronous) clears the window, counters and control, not the line stores.
module rgb_conv3x3_filter_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rcf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rcf_pkg::out_item_t             out_data,
  input  logic                           cfg_wen,
  input  logic [rcf_pkg::CfgIdxW-1:0]    cfg_idx,
  input  logic [rcf_pkg::CfgDataW-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MAC, S_DIV_GO, S_DIV_WAIT, S_OUT} state_t;

  state_t state_r;

  // configuration registers
  logic [23:0] k_top_r, k_mid_r, k_bot_r;
  logic [7:0]  divisor_r;
  logic [rcf_pkg::WidthW-1:0]  width_r;
  logic [rcf_pkg::HeightW-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_top_r   <= 24'd66049;
      k_mid_r   <= 24'd132098;
      k_bot_r   <= 24'd66049;
      divisor_r <= 8'd16;
      width_r   <= 12'd640;
      height_r  <= 13'd480;
    end else if (cfg_wen) begin
      priority case (cfg_idx)
        rcf_pkg::CFG_KERNEL_TOP:    k_top_r   <= cfg_wdata;
        rcf_pkg::CFG_KERNEL_MIDDLE: k_mid_r   <= cfg_wdata;
        rcf_pkg::CFG_KERNEL_BOTTOM: k_bot_r   <= cfg_wdata;
        rcf_pkg::CFG_DIVISOR:       divisor_r <= cfg_wdata[7:0];
        rcf_pkg::CFG_IMAGE_WIDTH:   width_r   <= cfg_wdata[rcf_pkg::WidthW-1:0];
        rcf_pkg::CFG_IMAGE_HEIGHT:  height_r  <= cfg_wdata[rcf_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  // clamp geometry
  logic [rcf_pkg::WidthW-1:0]  w_eff;
  logic [rcf_pkg::HeightW-1:0] h_eff;
  assign w_eff = (width_r < 12'd3) ? 12'd3 :
                 (width_r > 12'(rcf_pkg::MaxWidth)) ? 12'(rcf_pkg::MaxWidth) : width_r;
  assign h_eff = (height_r < 13'd3) ? 13'd3 :
                 (height_r > 13'(rcf_pkg::MaxHeight)) ? 13'(rcf_pkg::MaxHeight) : height_r;

  // position counters
  logic [rcf_pkg::ColW-1:0] col_r, x_cur, x_r;
  logic [rcf_pkg::RowW-1:0] row_r, y_cur, y_r;
  logic in_acc;
  logic interior_r, last_r;
  logic [rcf_pkg::PixW-1:0] bot_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign x_cur    = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
  assign y_cur    = ({1'b0, row_r} >= h_eff) ? '0 : row_r;

  // line store: read at accept, write back in the next cycle, in S_LOAD
  rcf_pkg::line_entry_t rd_entry, wr_entry;
  logic wr_en;

  rcf_line_mem u_mem (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (x_cur),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (x_r),
    .wr_data (wr_entry)
  );

  assign wr_en          = (state_r == S_LOAD);
  assign wr_entry.upper = rd_entry.lower;
  assign wr_entry.lower = bot_r;

  // window and tap shift lines
  logic [rcf_pkg::PixW-1:0] win_r [6];
  logic [rcf_pkg::PixW-1:0] tap_pix_r  [9];
  logic [7:0]               tap_coef_r [9];
  logic [3:0]               step_r;
  logic signed [rcf_pkg::SumW-1:0] acc_r [3];
  logic signed [16:0]       prod [3];
  logic [1:0]               ch_r;
  logic                     div_start, div_done;
  logic [7:0]               div_q;
  logic signed [rcf_pkg::SumW-1:0] div_in;
  rcf_pkg::out_item_t       out_r;

  for (genvar c = 0; c < 3; c++) begin : g_mul
    assign prod[c] = $signed({1'b0, tap_pix_r[0][8*c +: 8]}) * $signed(tap_coef_r[0]);
  end

  assign div_start = (state_r == S_DIV_GO);
  assign div_in    = acc_r[ch_r];

  rcf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (divisor_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            x_r        <= x_cur;
            y_r        <= y_cur;
            // pack red in the low byte, blue in the high byte
            bot_r      <= {in_data.blue_in, in_data.green_in, in_data.red_in};
            interior_r <= (x_cur >= 11'd2) && (y_cur >= 12'd2);
            last_r     <= ({1'b0, x_cur} == w_eff - 12'd1) &&
                          ({1'b0, y_cur} == h_eff - 13'd1);
            // advance raster position
            if ({1'b0, x_cur} + 12'd1 >= w_eff) begin
              col_r <= '0;
              row_r <= ({1'b0, y_cur} + 13'd1 >= h_eff) ? '0 : y_cur + 12'd1;
            end else begin
              col_r <= x_cur + 11'd1;
            end
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          // taps ordered column by column, top to bottom
          tap_pix_r[0] <= win_r[0];
          tap_pix_r[1] <= win_r[1];
          tap_pix_r[2] <= win_r[2];
          tap_pix_r[3] <= win_r[3];
          tap_pix_r[4] <= win_r[4];
          tap_pix_r[5] <= win_r[5];
          tap_pix_r[6] <= rd_entry.upper;
          tap_pix_r[7] <= rd_entry.lower;
          tap_pix_r[8] <= bot_r;
          for (int k = 0; k < 3; k++) begin
            tap_coef_r[3*k]     <= k_top_r[8*k +: 8];
            tap_coef_r[3*k + 1] <= k_mid_r[8*k +: 8];
            tap_coef_r[3*k + 2] <= k_bot_r[8*k +: 8];
          end
          win_r[0] <= win_r[3];
          win_r[1] <= win_r[4];
          win_r[2] <= win_r[5];
          win_r[3] <= rd_entry.upper;
          win_r[4] <= rd_entry.lower;
          win_r[5] <= bot_r;
          for (int c = 0; c < 3; c++) acc_r[c] <= '0;
          step_r  <= '0;
          state_r <= interior_r ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          for (int c = 0; c < 3; c++) begin
            acc_r[c] <= acc_r[c] + {{(rcf_pkg::SumW-17){prod[c][16]}}, prod[c]};
          end
          for (int i = 0; i < 8; i++) begin
            tap_pix_r[i]  <= tap_pix_r[i+1];
            tap_coef_r[i] <= tap_coef_r[i+1];
          end
          step_r <= step_r + 4'd1;
          if (step_r == 4'd8) begin
            ch_r    <= 2'd0;
            state_r <= S_DIV_GO;
          end
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (ch_r)
              2'd0:    out_r.red_out   <= div_q;
              2'd1:    out_r.green_out <= div_q;
              default: out_r.blue_out  <= div_q;
            endcase
            ch_r <= ch_r + 2'd1;
            if (ch_r == 2'd2) begin
              out_r.center_x   <= x_r - 11'd1;
              out_r.center_y   <= y_r - 12'd1;
              out_r.frame_last <= last_r;
              state_r          <= S_OUT;
            end else begin
              state_r <= S_DIV_GO;
            end
          end
        end
        S_OUT: begin
          // hold the result item until taken
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("item accepted while result pending");

  a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_LOAD)
    else $error("accepted item did not reach line store write-back");

  a_mac_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MAC |-> step_r <= 4'd8)
    else $error("tap counter overran");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV_WAIT)
    else $error("divider result with no channel waiting");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int HoldCycles  = 300;  // long receiver hold-off for the backpressure test
  localparam int DrainCycles = 60;   // margin after the last owed result
  localparam int IdleLimit   = 5000; // cycles without any handshake before giving up

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  rcf_pkg::in_item_t            in_data;
  logic                         out_valid;
  logic                         out_stall;
  rcf_pkg::out_item_t           out_data;
  logic                         cfg_wen;
  logic [rcf_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [rcf_pkg::CfgDataW-1:0] cfg_wdata;

  rgb_conv3x3_filter_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the configuration registers
  logic [23:0] kernel_rows [3];
  logic [7:0]  div_reg;
  logic [11:0] width_reg;
  logic [12:0] height_reg;

  // Shadow copy of the filter state
  logic [23:0] upper_line [rcf_pkg::MaxWidth];
  logic [23:0] lower_line [rcf_pkg::MaxWidth];
  logic [23:0] window_px [6];
  int unsigned col_pos;
  int unsigned row_pos;

  rcf_pkg::out_item_t filtered_px [$];  // filtered pixels still owed by the block
  int        errors;
  int        burst_left;
  int        hold_left;
  bit        hold_req;
  int        stall_mode;
  int        stall_span;
  int        idle_cycles;
  int        pixels_sent;

  // Signed coefficient k (0 = left) of one packed kernel row
  function automatic int kernel_coef(input logic [23:0] row_word, input int k);
    logic signed [7:0] b;
    b = row_word[8*k +: 8];
    return int'(b);
  endfunction

  // Advance the shadow filter by one pixel; queue the filtered pixel if it is interior
  task automatic filter_pixel(input rcf_pkg::in_item_t px);
    int unsigned w, h, x, y;
    logic [23:0] top, mid, bot;
    logic [23:0] taps [9];
    logic [7:0]  chan_out [3];
    int          sum, q, d;
    rcf_pkg::out_item_t res;
    w = (width_reg < 3) ? 3 : (width_reg > rcf_pkg::MaxWidth) ? rcf_pkg::MaxWidth : width_reg;
    h = (height_reg < 3) ? 3 :
        (height_reg > rcf_pkg::MaxHeight) ? rcf_pkg::MaxHeight : height_reg;
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    x = col_pos;
    y = row_pos;
    bot = {px.blue_in, px.green_in, px.red_in};
    top = upper_line[x];
    mid = lower_line[x];
    upper_line[x] = mid;
    lower_line[x] = bot;
    if (x >= 2 && y >= 2) begin
      d = (div_reg == 0) ? 1 : int'(div_reg);
      for (int r = 0; r < 3; r++) begin
        taps[r]     = window_px[r];
        taps[3 + r] = window_px[3 + r];
      end
      taps[6] = top;
      taps[7] = mid;
      taps[8] = bot;
      for (int c = 0; c < 3; c++) begin
        sum = 0;
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++)
            sum += int'(taps[3*k + r][8*c +: 8]) * kernel_coef(kernel_rows[r], k);
        q = sum / d;  // truncates toward zero
        if (q < 0) q = 0;
        if (q > 255) q = 255;
        chan_out[c] = q[7:0];
      end
      res.red_out    = chan_out[0];
      res.green_out  = chan_out[1];
      res.blue_out   = chan_out[2];
      res.center_x   = rcf_pkg::ColW'(x - 1);
      res.center_y   = rcf_pkg::RowW'(y - 1);
      res.frame_last = (x == w - 1 && y == h - 1);
      filtered_px.push_back(res);
    end
    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = top;
    window_px[4] = mid;
    window_px[5] = bot;
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_pos = x + 1;
    end
  endtask

  // Offer one pixel; bursts of random length separated by random gaps
  task automatic send_pixel(input logic [23:0] rgb);
    rcf_pkg::in_item_t px;
    int       gap;
    px = rgb;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    pixels_sent++;
    filter_pixel(px);
  endtask

  // Drop valid and wait until the block has nothing left in flight
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_px.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input rcf_pkg::cfg_idx_t idx, input logic [23:0] value);
    drain();
    cfg_wen   <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
    case (idx)
      rcf_pkg::CFG_KERNEL_TOP:    kernel_rows[0] = value;
      rcf_pkg::CFG_KERNEL_MIDDLE: kernel_rows[1] = value;
      rcf_pkg::CFG_KERNEL_BOTTOM: kernel_rows[2] = value;
      rcf_pkg::CFG_DIVISOR:       div_reg        = value[7:0];
      rcf_pkg::CFG_IMAGE_WIDTH:   width_reg      = value[11:0];
      rcf_pkg::CFG_IMAGE_HEIGHT:  height_reg     = value[12:0];
      default: ;
    endcase
  endtask

  task automatic set_kernel(input logic [23:0] t, input logic [23:0] m,
                            input logic [23:0] b, input logic [7:0] dv);
    write_reg(rcf_pkg::CFG_KERNEL_TOP, t);
    write_reg(rcf_pkg::CFG_KERNEL_MIDDLE, m);
    write_reg(rcf_pkg::CFG_KERNEL_BOTTOM, b);
    write_reg(rcf_pkg::CFG_DIVISOR, {16'd0, dv});
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(rcf_pkg::CFG_IMAGE_WIDTH, 24'(w));
    write_reg(rcf_pkg::CFG_IMAGE_HEIGHT, 24'(h));
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(24'($urandom));
  endtask

  // Reset kernel, black and white extremes; one interior pixel, last of frame
  task automatic test_default_kernel;
    set_geometry(3, 3);
    for (int i = 0; i < 9; i++)
      send_pixel((i % 2) ? 24'hFFFFFF : ((i % 3 == 0) ? 24'h00FF00 : 24'h000000));
  endtask

  // Saturate high with zero divisor (acts as 1), then low with negative weights
  task automatic test_clamping;
    set_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0);
    for (int i = 0; i < 9; i++) send_pixel(24'hFFFFFF);
    set_kernel(24'h808080, 24'h808080, 24'h808080, 8'd255);
    for (int i = 0; i < 9; i++) send_pixel(24'hFFFFFF);
  endtask

  // Width and height outside the range clamp; part of an over-wide first line
  task automatic test_geometry_limits;
    set_kernel(24'h010201, 24'h020402, 24'h010201, 8'd16);
    set_geometry(0, 1);
    send_random(9);
    set_geometry(4095, 3);
    send_random(40);
  endtask

  // Shrink width and height mid-frame so that the counters wrap
  task automatic test_midframe_shrink;
    set_kernel(24'hFF05FF, 24'h050505, 24'hFFFF05, 8'd7);
    set_geometry(8, 8191);
    send_random(8 * 3 + 6);
    write_reg(rcf_pkg::CFG_IMAGE_WIDTH, 24'd5);
    send_random(5 + 2);
    write_reg(rcf_pkg::CFG_IMAGE_HEIGHT, 24'd3);
    send_random(3 + 5 * 3);
  endtask

  // Hold the receiver off long enough that the block stalls its input
  task automatic test_backpressure;
    set_kernel(24'hFF08FF, 24'hFF08FF, 24'hFF08FF, 8'd3);
    set_geometry(6, 6);
    hold_req = 1'b1;
    send_random(36);
  endtask

  // Whole frames of random size, kernel and divisor
  task automatic test_random_frames;
    int          target;
    int          w, h, sel;
    logic [23:0] kr [3];
    logic [7:0]  dv;
    target = pixels_sent + 380;
    while (pixels_sent < target) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0: begin kr[0] = 24'h010201; kr[1] = 24'h020402; kr[2] = 24'h010201; end
        1: begin kr[0] = 24'hFF08FF; kr[1] = 24'hFF08FF; kr[2] = 24'hFF08FF; end
        2: begin kr[0] = 24'h000000; kr[1] = 24'hFF05FF; kr[2] = 24'h000000; end
        default: for (int r = 0; r < 3; r++) kr[r] = 24'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: dv = 8'd0;
        1: dv = 8'd1;
        2: dv = 8'd255;
        default: dv = 8'($urandom_range(1, 255));
      endcase
      set_kernel(kr[0], kr[1], kr[2], dv);
      w = $urandom_range(3, 12);
      h = $urandom_range(3, 6);
      set_geometry(w, h);
      send_random(w * h);
    end
  endtask

  // Receiver: random stall pattern, plus the long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= (hold_left > 0);
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldCycles;
      out_stall <= 1'b1;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(1, 40);
        stall_mode = $urandom_range(0, 2);
      end
      stall_span--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest filtered pixel owed
  always @(posedge clk) begin
    rcf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (filtered_px.size() == 0) begin
        $error("unexpected result item: %p", out_data);
        errors++;
      end else begin
        want = filtered_px.pop_front();
        if (out_data.red_out !== want.red_out) begin
          $error("red_out: expected %0d, got %0d", want.red_out, out_data.red_out);
          errors++;
        end
        if (out_data.green_out !== want.green_out) begin
          $error("green_out: expected %0d, got %0d", want.green_out, out_data.green_out);
          errors++;
        end
        if (out_data.blue_out !== want.blue_out) begin
          $error("blue_out: expected %0d, got %0d", want.blue_out, out_data.blue_out);
          errors++;
        end
        if (out_data.center_x !== want.center_x) begin
          $error("center_x: expected %0d, got %0d", want.center_x, out_data.center_x);
          errors++;
        end
        if (out_data.center_y !== want.center_y) begin
          $error("center_y: expected %0d, got %0d", want.center_y, out_data.center_y);
          errors++;
        end
        if (out_data.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0d, got %0d", want.frame_last, out_data.frame_last);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up after too many cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    errors      = 0;
    burst_left  = 0;
    hold_left   = 0;
    hold_req    = 1'b0;
    stall_mode  = 0;
    stall_span  = 0;
    idle_cycles = 0;
    pixels_sent = 0;
    kernel_rows[0] = 24'd66049;
    kernel_rows[1] = 24'd132098;
    kernel_rows[2] = 24'd66049;
    div_reg    = 8'd16;
    width_reg  = 12'd640;
    height_reg = 13'd480;
    for (int i = 0; i < 6; i++) window_px[i] = '0;
    col_pos = 0;
    row_pos = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wen   <= 1'b0;
    cfg_idx   <= rcf_pkg::CFG_KERNEL_TOP;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_kernel();
    test_clamping();
    test_geometry_limits();
    test_midframe_shrink();
    test_backpressure();
    test_random_frames();

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
